// ===== sv/spiea_pkg.sv =====
// Shared types, command and frame codes for the SPI EEPROM access sequencer.
// No dependencies; every other file refers to this package by scoped names.
package spiea_pkg;

   localparam int PAGE_BYTES = 64;
   localparam int PAGE_BITS  = $clog2(PAGE_BYTES);

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Request commands.
   localparam logic [2:0] CMD_BEGIN_READ  = 3'd0;
   localparam logic [2:0] CMD_BEGIN_WRITE = 3'd1;
   localparam logic [2:0] CMD_WRITE_BYTE  = 3'd2;
   localparam logic [2:0] CMD_READ_NEXT   = 3'd3;
   localparam logic [2:0] CMD_STATUS      = 3'd4;

   // Sequencer phases.
   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_WEL    = 3'd1;
   localparam logic [2:0] PH_WRITE  = 3'd2;
   localparam logic [2:0] PH_WIPMID = 3'd3;
   localparam logic [2:0] PH_WIPEND = 3'd4;
   localparam logic [2:0] PH_READ   = 3'd5;

   // Device opcodes.
   localparam logic [7:0] OP_WREN  = 8'h06;
   localparam logic [7:0] OP_RDSR  = 8'h05;
   localparam logic [7:0] OP_WRITE = 8'h02;
   localparam logic [7:0] OP_READ  = 8'h03;
   localparam logic [7:0] OP_WRDI  = 8'h04;
   localparam logic [7:0] OP_DUMMY = 8'h00;

   // Status register bits.
   localparam int SR_WIP = 0;
   localparam int SR_WEL = 1;

   // Reply capture modes.
   localparam logic [1:0] CAP_DISCARD = 2'd0;
   localparam logic [1:0] CAP_STATUS  = 2'd1;
   localparam logic [1:0] CAP_READ    = 2'd2;

   // Outcome codes.
   localparam logic [1:0] OUT_OK        = 2'd0;
   localparam logic [1:0] OUT_DONE      = 2'd1;
   localparam logic [1:0] OUT_TIMEOUT   = 2'd2;
   localparam logic [1:0] OUT_MISPLACED = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_POLL_LIMIT    = 1'b0;
   localparam logic CSR_DISABLE_AFTER = 1'b1;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [15:0] address;
      logic [7:0]  data;
      logic        last;
   } req_type;

   typedef struct packed {
      logic       frame_valid;
      logic [7:0] spi_byte;
      logic       deselect_after;
      logic [1:0] capture;
      logic [1:0] outcome;
      logic       last_frame;
   } rsp_type;

   typedef struct packed {
      logic       frame_valid;
      logic [7:0] spi_byte;
      logic       deselect_after;
      logic [1:0] capture;
   } item_type;

   // Everything one request causes: up to three items and the final outcome.
   typedef struct packed {
      item_type [2:0] items;
      logic [1:0]     count;
      logic [1:0]     outcome;
   } job_type;

   function automatic item_type mk_frame(logic [7:0] b, logic desel, logic [1:0] cap);
      item_type it;
      it.frame_valid    = 1'b1;
      it.spi_byte       = b;
      it.deselect_after = desel;
      it.capture        = cap;
      return it;
   endfunction

endpackage

// ===== sv/spiea_front.sv =====
// Front end: takes requests, tracks phase, address and poll count, and builds one job.
// Depends on spiea_pkg; feeds spiea_queue.
module spiea_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  spiea_pkg::req_type req_payload,
   input  logic               queue_full,
   output logic               req_stall,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [7:0]         csr_wdata,
   output logic               job_push,
   output spiea_pkg::job_type job
);

   logic [2:0]  phase_ff, phase_in;
   logic [15:0] addr_ff, addr_in;
   logic [7:0]  polls_ff, polls_in;
   logic [7:0]  poll_limit_ff;
   logic        disable_after_ff;

   logic [15:0]        addr_inc;
   logic               boundary;
   logic [7:0]         polls_sat;
   logic               timeout;
   spiea_pkg::job_type wait_job;
   spiea_pkg::job_type poll_job;
   logic               accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign job_push  = accept;

   assign addr_inc  = addr_ff + 16'd1;
   assign boundary  = (addr_inc[spiea_pkg::PAGE_BITS-1:0] == '0);
   assign polls_sat = (polls_ff == 8'hFF) ? polls_ff : polls_ff + 8'd1;
   assign timeout   = (poll_limit_ff != 8'd0) && (polls_sat >= poll_limit_ff);

   // A status reply that still shows busy: poll again, or give up on the wait.
   always_comb begin
      poll_job          = '0;
      poll_job.items[0] = spiea_pkg::mk_frame(spiea_pkg::OP_RDSR, 1'b0, spiea_pkg::CAP_DISCARD);
      poll_job.items[1] = spiea_pkg::mk_frame(spiea_pkg::OP_DUMMY, 1'b1, spiea_pkg::CAP_STATUS);
      poll_job.count    = 2'd2;
      poll_job.outcome  = spiea_pkg::OUT_OK;
      wait_job          = poll_job;
      if (timeout) begin
         wait_job         = '0;
         wait_job.count   = 2'd1;
         wait_job.outcome = spiea_pkg::OUT_TIMEOUT;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      addr_in     = addr_ff;
      polls_in    = polls_ff;
      job         = '0;
      job.count   = 2'd1;
      job.outcome = spiea_pkg::OUT_MISPLACED;
      case (req_payload.cmd)
         spiea_pkg::CMD_BEGIN_READ: begin
            if (phase_ff == spiea_pkg::PH_IDLE) begin
               job.items[0] = spiea_pkg::mk_frame(spiea_pkg::OP_READ, 1'b0,
                                                  spiea_pkg::CAP_DISCARD);
               job.items[1] = spiea_pkg::mk_frame(req_payload.address[15:8], 1'b0,
                                                  spiea_pkg::CAP_DISCARD);
               job.items[2] = spiea_pkg::mk_frame(req_payload.address[7:0], 1'b0,
                                                  spiea_pkg::CAP_DISCARD);
               job.count    = 2'd3;
               job.outcome  = spiea_pkg::OUT_OK;
               addr_in      = req_payload.address;
               phase_in     = spiea_pkg::PH_READ;
            end
         end
         spiea_pkg::CMD_BEGIN_WRITE: begin
            if (phase_ff == spiea_pkg::PH_IDLE) begin
               job          = poll_job;
               job.items[2] = poll_job.items[1];
               job.items[1] = poll_job.items[0];
               job.items[0] = spiea_pkg::mk_frame(spiea_pkg::OP_WREN, 1'b1,
                                                  spiea_pkg::CAP_DISCARD);
               job.count    = 2'd3;
               addr_in      = req_payload.address;
               polls_in     = 8'd0;
               phase_in     = spiea_pkg::PH_WEL;
            end
         end
         spiea_pkg::CMD_WRITE_BYTE: begin
            if (phase_ff == spiea_pkg::PH_WRITE) begin
               addr_in      = addr_inc;
               job.items[0] = spiea_pkg::mk_frame(req_payload.data,
                                                  boundary || req_payload.last,
                                                  spiea_pkg::CAP_DISCARD);
               job.outcome  = spiea_pkg::OUT_OK;
               if (boundary || req_payload.last) begin
                  job.items[1] = poll_job.items[0];
                  job.items[2] = poll_job.items[1];
                  job.count    = 2'd3;
                  polls_in     = 8'd0;
                  phase_in     = req_payload.last ? spiea_pkg::PH_WIPEND
                                                  : spiea_pkg::PH_WIPMID;
               end
            end
         end
         spiea_pkg::CMD_READ_NEXT: begin
            if (phase_ff == spiea_pkg::PH_READ) begin
               addr_in      = addr_inc;
               job.items[0] = spiea_pkg::mk_frame(spiea_pkg::OP_DUMMY, req_payload.last,
                                                  spiea_pkg::CAP_READ);
               job.outcome  = spiea_pkg::OUT_OK;
               if (req_payload.last) begin
                  job.outcome = spiea_pkg::OUT_DONE;
                  phase_in    = spiea_pkg::PH_IDLE;
               end
            end
         end
         spiea_pkg::CMD_STATUS: begin
            case (phase_ff)
               spiea_pkg::PH_WEL: begin
                  if (!req_payload.data[spiea_pkg::SR_WEL]) begin
                     job      = wait_job;
                     polls_in = polls_sat;
                     if (timeout) begin
                        phase_in = spiea_pkg::PH_IDLE;
                     end
                  end else begin
                     job.items[0] = spiea_pkg::mk_frame(spiea_pkg::OP_WRITE, 1'b0,
                                                        spiea_pkg::CAP_DISCARD);
                     job.items[1] = spiea_pkg::mk_frame(addr_ff[15:8], 1'b0,
                                                        spiea_pkg::CAP_DISCARD);
                     job.items[2] = spiea_pkg::mk_frame(addr_ff[7:0], 1'b0,
                                                        spiea_pkg::CAP_DISCARD);
                     job.count    = 2'd3;
                     job.outcome  = spiea_pkg::OUT_OK;
                     phase_in     = spiea_pkg::PH_WRITE;
                  end
               end
               spiea_pkg::PH_WIPMID: begin
                  if (req_payload.data[spiea_pkg::SR_WIP]) begin
                     job      = wait_job;
                     polls_in = polls_sat;
                     if (timeout) begin
                        phase_in = spiea_pkg::PH_IDLE;
                     end
                  end else begin
                     job          = poll_job;
                     job.items[2] = poll_job.items[1];
                     job.items[1] = poll_job.items[0];
                     job.items[0] = spiea_pkg::mk_frame(spiea_pkg::OP_WREN, 1'b1,
                                                        spiea_pkg::CAP_DISCARD);
                     job.count    = 2'd3;
                     polls_in     = 8'd0;
                     phase_in     = spiea_pkg::PH_WEL;
                  end
               end
               spiea_pkg::PH_WIPEND: begin
                  if (req_payload.data[spiea_pkg::SR_WIP]) begin
                     job      = wait_job;
                     polls_in = polls_sat;
                     if (timeout) begin
                        phase_in = spiea_pkg::PH_IDLE;
                     end
                  end else begin
                     // Without write-disable the completion is a frameless transfer.
                     if (disable_after_ff) begin
                        job.items[0] = spiea_pkg::mk_frame(spiea_pkg::OP_WRDI, 1'b1,
                                                           spiea_pkg::CAP_DISCARD);
                     end
                     job.outcome = spiea_pkg::OUT_DONE;
                     phase_in    = spiea_pkg::PH_IDLE;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= spiea_pkg::PH_IDLE;
         addr_ff          <= 16'd0;
         polls_ff         <= 8'd0;
         poll_limit_ff    <= 8'd0;
         disable_after_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            addr_ff  <= addr_in;
            polls_ff <= polls_in;
         end
         if (csr_write) begin
            if (csr_index == spiea_pkg::CSR_POLL_LIMIT) begin
               poll_limit_ff <= csr_wdata;
            end else begin
               disable_after_ff <= csr_wdata[0];
            end
         end
      end
   end

endmodule

// ===== sv/spiea_queue.sv =====
// Short job queue between the front end and the frame emitter.
// Depends on spiea_pkg for the job type and depth.
module spiea_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  spiea_pkg::job_type push_job,
   input  logic               pop,
   output logic               full,
   output logic               head_valid,
   output spiea_pkg::job_type head_job
);

   spiea_pkg::job_type mem_ff [spiea_pkg::QUEUE_DEPTH];
   logic [spiea_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [spiea_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == spiea_pkg::QUEUE_CNT_W'(spiea_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + spiea_pkg::QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - spiea_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + spiea_pkg::QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + spiea_pkg::QUEUE_PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

// ===== sv/spiea_back.sv =====
// Frame emitter: walks the items of the job at the queue head into the result register.
// Depends on spiea_pkg; reads from spiea_queue.
module spiea_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  spiea_pkg::job_type head_job,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output spiea_pkg::rsp_type rsp_payload
);

   logic [1:0]         idx_ff;
   logic               rsp_valid_ff;
   spiea_pkg::rsp_type rsp_ff, rsp_in;
   logic               load;
   logic               final_item;
   spiea_pkg::item_type cur;

   assign load       = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign final_item = (idx_ff == head_job.count - 2'd1);
   assign pop        = load && final_item;
   assign cur        = head_job.items[idx_ff];

   always_comb begin
      rsp_in.frame_valid    = cur.frame_valid;
      rsp_in.spi_byte       = cur.spi_byte;
      rsp_in.deselect_after = cur.deselect_after;
      rsp_in.capture        = cur.capture;
      rsp_in.outcome        = final_item ? head_job.outcome : spiea_pkg::OUT_OK;
      rsp_in.last_frame     = final_item;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            idx_ff <= final_item ? 2'd0 : idx_ff + 2'd1;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== sv/spi_eeprom_access_sequencer.sv =====
// Top level of the SPI EEPROM access sequencer: front end, job queue and frame emitter.
// Depends on spiea_pkg, spiea_front, spiea_queue and spiea_back.

// Each request yields one to three result transfers (SPI frames, or one frameless
// outcome transfer). The front end takes a request every cycle while its four-entry job
// queue has room; the frame emitter behind it hands out one result transfer per cycle
// while the output is not stalled, through a registered output, so a request
// occupies the output once for each of its results. The output stage is the limiting unit.
// Configuration writes are always ready and must be issued while the block is idle.
// No clearing pass follows reset.
module spi_eeprom_access_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  spiea_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output spiea_pkg::rsp_type rsp_payload,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [7:0]         csr_wdata
);

   logic               queue_full;
   logic               job_push;
   spiea_pkg::job_type push_job;
   logic               head_valid;
   spiea_pkg::job_type head_job;
   logic               pop;

   assign csr_ready = 1'b1;

   spiea_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .req_stall   (req_stall),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .job_push    (job_push),
      .job         (push_job)
   );

   spiea_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   spiea_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_job    (head_job),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== verif/spi_eeprom_access_sequencer_tb.sv =====
// Self-checking testbench for spi_eeprom_access_sequencer: directed and random request
// traffic under random idling, with every result transfer predicted and checked in order.
// Depends on spiea_pkg and the sequencer RTL.
module spi_eeprom_access_sequencer_tb;

   // Command codes the block must refuse.
   localparam logic [2:0] CMD_BAD_LO = 3'd5;
   localparam logic [2:0] CMD_BAD_HI = 3'd7;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   spiea_pkg::req_type req_payload = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   spiea_pkg::rsp_type rsp_payload;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic               csr_index = 1'b0;
   logic [7:0]         csr_wdata = '0;

   // Mirror of the sequencer state and its registers.
   logic [2:0]  seq_phase = spiea_pkg::PH_IDLE;
   logic [15:0] seq_addr = '0;
   logic [7:0]  seq_polls = '0;
   logic [7:0]  poll_limit = '0;
   logic        wrdi_on = 1'b0;

   spiea_pkg::req_type req_pending[$];
   spiea_pkg::rsp_type frames_due[$];
   spiea_pkg::rsp_type frame_buf[$];
   int      fail_count = 0;
   int      queued_items = 0;
   int      req_hold = 0;
   int      rsp_hold = 0;
   bit      req_calm = 1'b0;
   bit      rsp_calm = 1'b0;

   spi_eeprom_access_sequencer u_top (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int draw_wait(inout bit calm);
      if ($urandom_range(0, 39) == 0) calm = !calm;
      return calm ? 0 : int'($urandom_range(0, 12));
   endfunction

   function automatic string describe(spiea_pkg::rsp_type r);
      return $sformatf("frame=%0d byte=%02h desel=%0d cap=%0d outcome=%0d last=%0d",
                       r.frame_valid, r.spi_byte, r.deselect_after, r.capture,
                       r.outcome, r.last_frame);
   endfunction

   // ---------------------------------------------------------------- prediction

   function automatic void add_frame(logic [7:0] b, logic desel, logic [1:0] cap);
      spiea_pkg::rsp_type f;
      f = '0;
      f.frame_valid    = 1'b1;
      f.spi_byte       = b;
      f.deselect_after = desel;
      f.capture        = cap;
      frame_buf.push_back(f);
   endfunction

   function automatic void add_status_poll();
      add_frame(spiea_pkg::OP_RDSR, 1'b0, spiea_pkg::CAP_DISCARD);
      add_frame(spiea_pkg::OP_DUMMY, 1'b1, spiea_pkg::CAP_STATUS);
   endfunction

   // A status reply that still shows the device waiting: poll again, or give up.
   function automatic logic [1:0] poll_or_abort();
      if (seq_polls != 8'hFF) seq_polls++;
      if (poll_limit != 0 && seq_polls >= poll_limit) begin
         seq_phase = spiea_pkg::PH_IDLE;
         return spiea_pkg::OUT_TIMEOUT;
      end
      add_status_poll();
      return spiea_pkg::OUT_OK;
   endfunction

   function automatic void predict_frames(spiea_pkg::req_type r);
      logic [1:0] verdict;
      logic       at_edge;
      verdict = spiea_pkg::OUT_OK;
      frame_buf.delete();
      if (r.cmd == spiea_pkg::CMD_BEGIN_READ && seq_phase == spiea_pkg::PH_IDLE) begin
         seq_addr = r.address;
         add_frame(spiea_pkg::OP_READ, 1'b0, spiea_pkg::CAP_DISCARD);
         add_frame(r.address[15:8], 1'b0, spiea_pkg::CAP_DISCARD);
         add_frame(r.address[7:0], 1'b0, spiea_pkg::CAP_DISCARD);
         seq_phase = spiea_pkg::PH_READ;
      end else if (r.cmd == spiea_pkg::CMD_BEGIN_WRITE &&
                   seq_phase == spiea_pkg::PH_IDLE) begin
         seq_addr  = r.address;
         seq_polls = '0;
         add_frame(spiea_pkg::OP_WREN, 1'b1, spiea_pkg::CAP_DISCARD);
         add_status_poll();
         seq_phase = spiea_pkg::PH_WEL;
      end else if (r.cmd == spiea_pkg::CMD_WRITE_BYTE &&
                   seq_phase == spiea_pkg::PH_WRITE) begin
         seq_addr = seq_addr + 16'd1;
         at_edge  = (seq_addr % spiea_pkg::PAGE_BYTES) == 0;
         add_frame(r.data, at_edge || r.last, spiea_pkg::CAP_DISCARD);
         // The final byte wins over a page boundary: no re-addressing after it.
         if (r.last || at_edge) begin
            seq_polls = '0;
            add_status_poll();
            seq_phase = r.last ? spiea_pkg::PH_WIPEND : spiea_pkg::PH_WIPMID;
         end
      end else if (r.cmd == spiea_pkg::CMD_READ_NEXT && seq_phase == spiea_pkg::PH_READ) begin
         seq_addr = seq_addr + 16'd1;
         add_frame(spiea_pkg::OP_DUMMY, r.last, spiea_pkg::CAP_READ);
         if (r.last) begin
            seq_phase = spiea_pkg::PH_IDLE;
            verdict   = spiea_pkg::OUT_DONE;
         end
      end else if (r.cmd == spiea_pkg::CMD_STATUS && seq_phase == spiea_pkg::PH_WEL) begin
         if (!r.data[spiea_pkg::SR_WEL]) begin
            verdict = poll_or_abort();
         end else begin
            add_frame(spiea_pkg::OP_WRITE, 1'b0, spiea_pkg::CAP_DISCARD);
            add_frame(seq_addr[15:8], 1'b0, spiea_pkg::CAP_DISCARD);
            add_frame(seq_addr[7:0], 1'b0, spiea_pkg::CAP_DISCARD);
            seq_phase = spiea_pkg::PH_WRITE;
         end
      end else if (r.cmd == spiea_pkg::CMD_STATUS && seq_phase == spiea_pkg::PH_WIPMID) begin
         if (r.data[spiea_pkg::SR_WIP]) begin
            verdict = poll_or_abort();
         end else begin
            seq_polls = '0;
            add_frame(spiea_pkg::OP_WREN, 1'b1, spiea_pkg::CAP_DISCARD);
            add_status_poll();
            seq_phase = spiea_pkg::PH_WEL;
         end
      end else if (r.cmd == spiea_pkg::CMD_STATUS && seq_phase == spiea_pkg::PH_WIPEND) begin
         if (r.data[spiea_pkg::SR_WIP]) begin
            verdict = poll_or_abort();
         end else begin
            if (wrdi_on) add_frame(spiea_pkg::OP_WRDI, 1'b1, spiea_pkg::CAP_DISCARD);
            seq_phase = spiea_pkg::PH_IDLE;
            verdict   = spiea_pkg::OUT_DONE;
         end
      end else begin
         verdict = spiea_pkg::OUT_MISPLACED;
      end
      if (frame_buf.size() == 0) frame_buf.push_back('0);
      frame_buf[frame_buf.size() - 1].outcome    = verdict;
      frame_buf[frame_buf.size() - 1].last_frame = 1'b1;
      foreach (frame_buf[i]) frames_due.push_back(frame_buf[i]);
   endfunction

   // ------------------------------------------------------- request driver

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_frames(req_payload);
            req_hold = draw_wait(req_calm);
         end
         if (!req_valid || !req_stall) begin
            if (req_hold != 0) begin
               req_valid <= 1'b0;
               req_hold--;
            end else if (req_pending.size() != 0) begin
               req_valid   <= 1'b1;
               req_payload <= req_pending.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------- result monitor

   always @(posedge clock) begin
      spiea_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (frames_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result transfer: got %s", describe(rsp_payload));
            end else begin
               want = frames_due.pop_front();
               if (rsp_payload.frame_valid !== want.frame_valid ||
                   rsp_payload.spi_byte !== want.spi_byte ||
                   rsp_payload.deselect_after !== want.deselect_after ||
                   rsp_payload.capture !== want.capture ||
                   rsp_payload.outcome !== want.outcome ||
                   rsp_payload.last_frame !== want.last_frame) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("result mismatch: expected %s, got %s",
                              describe(want), describe(rsp_payload));
               end
            end
            rsp_hold = draw_wait(rsp_calm);
         end
         if (rsp_hold != 0) begin
            rsp_stall <= 1'b1;
            rsp_hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------- stimulus

   function automatic void queue_req(logic [2:0] cmd, logic [15:0] a, logic [7:0] d,
                                     logic l);
      spiea_pkg::req_type r;
      r.cmd     = cmd;
      r.address = a;
      r.data    = d;
      r.last    = l;
      req_pending.push_back(r);
      queued_items++;
   endfunction

   // Status replies for one wait: up to four busy ones, then the one that ends the wait.
   function automatic void queue_status_wait(int sr_bit, logic done_level);
      logic [7:0] d;
      int         busy;
      busy = ($urandom_range(0, 9) < 6) ? 0 : int'($urandom_range(1, 4));
      for (int i = 0; i <= busy; i++) begin
         d = 8'($urandom);
         d[sr_bit] = (i == busy) ? done_level : !done_level;
         queue_req(spiea_pkg::CMD_STATUS, 16'($urandom), d, 1'($urandom));
      end
   endfunction

   function automatic void queue_write_block();
      logic [15:0] a;
      int          len;
      logic        at_edge;
      logic        fin;
      a = 16'($urandom);
      if ($urandom_range(0, 2) == 0) a[5:0] = 6'(63 - $urandom_range(0, 5));
      if ($urandom_range(0, 7) == 0) a[15:6] = '1;
      len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(9, 70))
                                        : int'($urandom_range(1, 8));
      queue_req(spiea_pkg::CMD_BEGIN_WRITE, a, 8'($urandom), 1'($urandom));
      queue_status_wait(spiea_pkg::SR_WEL, 1'b1);
      for (int i = 0; i < len; i++) begin
         a       = a + 16'd1;
         at_edge = (a % spiea_pkg::PAGE_BYTES) == 0;
         fin     = (i == len - 1);
         queue_req(spiea_pkg::CMD_WRITE_BYTE, 16'($urandom), 8'($urandom), fin);
         if (fin || at_edge) queue_status_wait(spiea_pkg::SR_WIP, 1'b0);
         if (!fin && at_edge) queue_status_wait(spiea_pkg::SR_WEL, 1'b1);
      end
   endfunction

   function automatic void queue_read_block();
      int n;
      n = int'($urandom_range(1, 6));
      queue_req(spiea_pkg::CMD_BEGIN_READ, 16'($urandom), 8'($urandom), 1'($urandom));
      for (int i = 1; i <= n; i++)
         queue_req(spiea_pkg::CMD_READ_NEXT, 16'($urandom), 8'($urandom), i == n);
   endfunction

   task automatic run_traffic(input int goal);
      int pick;
      queued_items = 0;
      while (queued_items < goal) begin
         pick = int'($urandom_range(0, 9));
         if (pick < 5) begin
            queue_write_block();
         end else if (pick < 8) begin
            queue_read_block();
         end else begin
            repeat ($urandom_range(1, 3))
               queue_req(3'($urandom_range(0, 7)), 16'($urandom), 8'($urandom),
                         1'($urandom));
         end
      end
   endtask

   task automatic write_reg(input logic idx, input logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      if (idx == spiea_pkg::CSR_POLL_LIMIT) poll_limit = value;
      else wrdi_on = value[0];
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (req_pending.size() != 0 || req_valid || frames_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      logic [7:0] limit_plan[5];
      logic       wrdi_plan[5];
      limit_plan = '{8'd0, 8'd255, 8'd1, 8'd3, 8'($urandom_range(2, 8))};
      wrdi_plan  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'($urandom_range(0, 1))};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      write_reg(spiea_pkg::CSR_POLL_LIMIT, 8'd2);
      write_reg(spiea_pkg::CSR_DISABLE_AFTER, 8'd0);
      queue_req(CMD_BAD_HI, 16'hFFFF, 8'hFF, 1'b1);
      queue_req(spiea_pkg::CMD_READ_NEXT, 16'h0000, 8'h00, 1'b0);
      // Read across the top of the address space.
      queue_req(spiea_pkg::CMD_BEGIN_READ, 16'hFFFF, 8'h00, 1'b0);
      queue_req(spiea_pkg::CMD_READ_NEXT, 16'h0000, 8'hFF, 1'b0);
      queue_req(spiea_pkg::CMD_READ_NEXT, 16'hFFFF, 8'h00, 1'b1);
      // Write that wraps to address zero, a page boundary, then times out at the end.
      queue_req(spiea_pkg::CMD_BEGIN_WRITE, 16'hFFFE, 8'h00, 1'b0);
      queue_req(spiea_pkg::CMD_STATUS, 16'h0000, 8'h00, 1'b0);
      queue_req(spiea_pkg::CMD_STATUS, 16'h0000, 8'h02, 1'b0);
      queue_req(spiea_pkg::CMD_WRITE_BYTE, 16'h0000, 8'hFF, 1'b0);
      queue_req(spiea_pkg::CMD_WRITE_BYTE, 16'hFFFF, 8'h00, 1'b0);
      queue_req(spiea_pkg::CMD_STATUS, 16'h0000, 8'h01, 1'b0);
      queue_req(spiea_pkg::CMD_STATUS, 16'h0000, 8'h00, 1'b0);
      queue_req(spiea_pkg::CMD_STATUS, 16'h0000, 8'hFE, 1'b0);
      queue_req(spiea_pkg::CMD_WRITE_BYTE, 16'h0000, 8'h5A, 1'b1);
      queue_req(spiea_pkg::CMD_STATUS, 16'h0000, 8'hFF, 1'b0);
      queue_req(spiea_pkg::CMD_STATUS, 16'h0000, 8'hFF, 1'b0);
      // Final byte lands on a page boundary; completion without write-disable.
      queue_req(spiea_pkg::CMD_BEGIN_WRITE, 16'h003F, 8'h00, 1'b0);
      queue_req(spiea_pkg::CMD_STATUS, 16'h0000, 8'h02, 1'b0);
      queue_req(spiea_pkg::CMD_WRITE_BYTE, 16'h0000, 8'hA5, 1'b1);
      queue_req(spiea_pkg::CMD_STATUS, 16'h0000, 8'hFC, 1'b0);
      // Timeout while waiting for the write enable latch.
      queue_req(spiea_pkg::CMD_BEGIN_WRITE, 16'h1234, 8'h00, 1'b0);
      queue_req(spiea_pkg::CMD_BEGIN_READ, 16'h0000, 8'h00, 1'b0);
      queue_req(spiea_pkg::CMD_STATUS, 16'h0000, 8'h00, 1'b0);
      queue_req(spiea_pkg::CMD_STATUS, 16'h0000, 8'h00, 1'b0);
      queue_req(spiea_pkg::CMD_STATUS, 16'h0000, 8'h00, 1'b0);
      queue_req(CMD_BAD_LO, 16'h0000, 8'h00, 1'b0);
      wait_drained();

      for (int p = 0; p < 5; p++) begin
         write_reg(spiea_pkg::CSR_POLL_LIMIT, limit_plan[p]);
         write_reg(spiea_pkg::CSR_DISABLE_AFTER, {7'd0, wrdi_plan[p]});
         run_traffic(60);
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (frames_due.size() != 0) begin
         fail_count++;
         $display("%0d expected result transfers never arrived", frames_due.size());
      end
      if (fail_count == 0)
         $display("** spi_eeprom_access_sequencer: PASSED **");
      else
         $display("** spi_eeprom_access_sequencer: FAILED **");
      $finish;
   end

   initial begin
      #2000000;
      $display("** spi_eeprom_access_sequencer: FAILED **");
      $finish;
   end

endmodule
